### rtl/eco_pkg.sv
// Shared constants, state type and helper functions for the camera orientation block.
package eco_pkg;

   localparam int TABLE_LEN = 24;

   localparam logic signed [18:0] HALF_TURN    = 19'sd11520;
   localparam logic signed [18:0] FULL_TURN    = 19'sd23040;
   localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;
   localparam logic signed [15:0] HALF_TURN_16 = 16'sd11520;
   localparam logic signed [17:0] PITCH_LIMIT  = 18'sd5696;
   localparam logic signed [17:0] ZOOM_MIN     = 18'sd256;
   localparam logic signed [17:0] ZOOM_MAX     = 18'sd25600;
   localparam logic signed [20:0] ONE_Q14      = 21'sd16384;
   localparam logic signed [31:0] CORDIC_GAIN  = 32'sd326016437;
   localparam logic [15:0]        QUOT_MAX     = 16'd16384;
   localparam logic signed [14:0] YAW_RESET    = -15'sd5760;
   localparam logic signed [15:0] UP_X_RESET   = 16'sd0;
   localparam logic signed [15:0] UP_Y_RESET   = 16'sd16384;
   localparam logic signed [15:0] UP_Z_RESET   = 16'sd0;

   localparam logic [2:0] REG_UP_X       = 3'd0;
   localparam logic [2:0] REG_UP_Y       = 3'd1;
   localparam logic [2:0] REG_UP_Z       = 3'd2;
   localparam logic [2:0] REG_INIT_YAW   = 3'd3;
   localparam logic [2:0] REG_INIT_PITCH = 3'd4;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_LOAD  = 10'b0000000010,
      S_CORD  = 10'b0000000100,
      S_STORE = 10'b0000001000,
      S_FRONT = 10'b0000010000,
      S_CROSS = 10'b0000100000,
      S_SQR   = 10'b0001000000,
      S_SQRT  = 10'b0010000000,
      S_DIV   = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   // Arctangent of 2^-i in units of 2^-22 degree.
   function automatic logic [27:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0:    return 28'd188743680;
         5'd1:    return 28'd111421900;
         5'd2:    return 28'd58872272;
         5'd3:    return 28'd29884485;
         5'd4:    return 28'd15000234;
         5'd5:    return 28'd7507429;
         5'd6:    return 28'd3754631;
         5'd7:    return 28'd1877430;
         5'd8:    return 28'd938729;
         5'd9:    return 28'd469366;
         5'd10:   return 28'd234683;
         5'd11:   return 28'd117342;
         5'd12:   return 28'd58671;
         5'd13:   return 28'd29335;
         5'd14:   return 28'd14668;
         5'd15:   return 28'd7334;
         5'd16:   return 28'd3667;
         5'd17:   return 28'd1833;
         5'd18:   return 28'd917;
         5'd19:   return 28'd458;
         5'd20:   return 28'd229;
         5'd21:   return 28'd115;
         5'd22:   return 28'd57;
         5'd23:   return 28'd29;
         default: return 28'd0;
      endcase
   endfunction

   // Reduces an angle into one full turn centered on zero.
   function automatic logic signed [14:0] wrap_angle(input logic signed [17:0] a);
      logic signed [18:0] t;
      t = $signed({a[17], a}) + HALF_TURN;
      if (t < 0) t = t + FULL_TURN;
      if (t < 0) t = t + FULL_TURN;
      if (t >= FULL_TURN) t = t - FULL_TURN;
      if (t >= FULL_TURN) t = t - FULL_TURN;
      t = t - HALF_TURN;
      return t[14:0];
   endfunction

   function automatic logic signed [15:0] clamp_q14(input logic signed [20:0] v);
      if (v > ONE_Q14) return 16'sd16384;
      if (v < -ONE_Q14) return -16'sd16384;
      return v[15:0];
   endfunction

endpackage

### rtl/euler_camera_orientation.sv
// Fly-camera orientation: angle update, CORDIC sine/cosine and normalized basis vectors.
// A new item is taken only in the idle state; req_stall stays high until the current item
// is handed over. The single CORDIC stage, the shared 32x32 multiplier, the bit-per-cycle
// square root and the bit-per-cycle divider do the work of each item in turn.
// A finished result waits in its output register while the next item is already at work.
// Reset is synchronous: yaw -90 degrees, pitch 0, zoom ZOOM_RESET clamped to 256..25600, world up +Y, no result.
module euler_camera_orientation #(
   parameter int ZOOM_RESET   = 11520,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_yaw_delta,
   input  logic signed [15:0] req_pitch_delta,
   input  logic signed [15:0] req_zoom_delta,
   input  logic               req_limit_pitch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_front_x,
   output logic signed [15:0] rsp_front_y,
   output logic signed [15:0] rsp_front_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   output logic signed [14:0] rsp_yaw_now,
   output logic signed [14:0] rsp_pitch_now,
   output logic        [14:0] rsp_zoom_now,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_data
);

   // The CORDIC runs at most as many steps as the arctangent table holds.
   localparam int STEPS = (CORDIC_STEPS < eco_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : eco_pkg::TABLE_LEN;
   localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);
   localparam logic [14:0] ZOOM_INIT = 15'((ZOOM_RESET < 256) ? 256 :
                                           ((ZOOM_RESET > 25600) ? 25600 : ZOOM_RESET));

   eco_pkg::state_type state_ff, state_in;

   // Camera state and the world up vector.
   logic signed [14:0] yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic        [14:0] zoom_ff, zoom_in;
   logic signed [15:0] up_ff [3];
   logic signed [15:0] up_in [3];

   // Sequencer bookkeeping.
   logic       sel_ff, sel_in, neg_ff, neg_in, pass_ff, pass_in;
   logic [4:0] iter_ff, iter_in, cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;

   // CORDIC datapath and its results.
   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [31:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;

   // Basis vectors, cross product and normalization datapath.
   logic signed [15:0] f_ff [3];
   logic signed [15:0] f_in [3];
   logic signed [15:0] r_ff [3];
   logic signed [15:0] r_in [3];
   logic signed [15:0] u_ff [3];
   logic signed [15:0] u_in [3];
   logic signed [31:0] c_ff [3];
   logic signed [31:0] c_in [3];
   logic signed [31:0] acc_ff, acc_in;
   logic        [63:0] rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic        [47:0] num_ff, num_in, den_ff, den_in;
   logic        [15:0] quo_ff, quo_in;

   // The one multiplier; its product is always registered before use.
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff, prod_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] of_ff [3];
   logic signed [15:0] of_in [3];
   logic signed [15:0] or_ff [3];
   logic signed [15:0] or_in [3];
   logic signed [15:0] ou_ff [3];
   logic signed [15:0] ou_in [3];
   logic signed [14:0] oyaw_ff, oyaw_in, opitch_ff, opitch_in;
   logic        [14:0] ozoom_ff, ozoom_in;

   assign prod_in   = mul_a * mul_b;
   assign req_stall = (state_ff != eco_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      logic signed [17:0] yaw_sum, pitch_sum, zoom_sum;
      logic signed [15:0] ang, ang_f;
      logic signed [31:0] dx, dy;
      logic signed [63:0] fr_t;
      logic signed [32:0] fy_t;
      logic signed [15:0] av [3];
      logic signed [15:0] bv [3];
      logic        [63:0] trial;
      logic        [31:0] mag;
      logic        [15:0] qc;
      logic signed [15:0] qs;

      yaw_sum = '0; pitch_sum = '0; zoom_sum = '0;
      ang = '0; ang_f = '0; dx = '0; dy = '0; fr_t = '0; fy_t = '0;
      trial = '0; mag = '0; qc = '0; qs = '0;
      if (pass_ff) begin
         av = r_ff;
         bv = f_ff;
      end else begin
         av = f_ff;
         bv = up_ff;
      end

      state_in = state_ff;
      yaw_in = yaw_ff; pitch_in = pitch_ff; zoom_in = zoom_ff; up_in = up_ff;
      sel_in = sel_ff; neg_in = neg_ff; pass_in = pass_ff;
      iter_in = iter_ff; cnt_in = cnt_ff; comp_in = comp_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      cy_in = cy_ff; sy_in = sy_ff; cp_in = cp_ff; sp_in = sp_ff;
      f_in = f_ff; r_in = r_ff; u_in = u_ff; c_in = c_ff; acc_in = acc_ff;
      rem_in = rem_ff; root_in = root_ff; bit_in = bit_ff;
      num_in = num_ff; den_in = den_ff; quo_in = quo_ff;
      mul_a = '0; mul_b = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      of_in = of_ff; or_in = or_ff; ou_in = ou_ff;
      oyaw_in = oyaw_ff; opitch_in = opitch_ff; ozoom_in = ozoom_ff;

      case (state_ff)
         eco_pkg::S_IDLE: begin
            if (req_valid) begin
               // Yaw always wraps; pitch is clamped or wrapped as the item asks.
               yaw_sum = 18'(yaw_ff) + 18'(req_yaw_delta);
               yaw_in  = eco_pkg::wrap_angle(yaw_sum);
               pitch_sum = 18'(pitch_ff) + 18'(req_pitch_delta);
               if (req_limit_pitch) begin
                  if (pitch_sum > eco_pkg::PITCH_LIMIT)
                     pitch_in = 15'(eco_pkg::PITCH_LIMIT);
                  else if (pitch_sum < -eco_pkg::PITCH_LIMIT)
                     pitch_in = 15'(-eco_pkg::PITCH_LIMIT);
                  else
                     pitch_in = pitch_sum[14:0];
               end else begin
                  pitch_in = eco_pkg::wrap_angle(pitch_sum);
               end
               zoom_sum = $signed({3'b000, zoom_ff}) - 18'(req_zoom_delta);
               if (zoom_sum < eco_pkg::ZOOM_MIN)
                  zoom_in = 15'(eco_pkg::ZOOM_MIN);
               else if (zoom_sum > eco_pkg::ZOOM_MAX)
                  zoom_in = 15'(eco_pkg::ZOOM_MAX);
               else
                  zoom_in = zoom_sum[14:0];
               sel_in   = 1'b0;
               state_in = eco_pkg::S_LOAD;
            end
         end

         eco_pkg::S_LOAD: begin
            // Fold into a half turn around zero; a folded angle has its results negated.
            ang    = sel_ff ? 16'(pitch_ff) : 16'(yaw_ff);
            ang_f  = ang;
            neg_in = 1'b0;
            if (ang > eco_pkg::QUARTER_TURN) begin
               ang_f  = ang - eco_pkg::HALF_TURN_16;
               neg_in = 1'b1;
            end else if (ang < -eco_pkg::QUARTER_TURN) begin
               ang_f  = ang + eco_pkg::HALF_TURN_16;
               neg_in = 1'b1;
            end
            x_in     = eco_pkg::CORDIC_GAIN;
            y_in     = '0;
            z_in     = {ang_f, 16'h0000};
            iter_in  = '0;
            state_in = eco_pkg::S_CORD;
         end

         eco_pkg::S_CORD: begin
            dx = y_ff >>> iter_ff;
            dy = x_ff >>> iter_ff;
            if (z_ff >= 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - $signed({4'b0000, eco_pkg::atan_entry(iter_ff)});
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + $signed({4'b0000, eco_pkg::atan_entry(iter_ff)});
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == LAST_STEP) state_in = eco_pkg::S_STORE;
         end

         eco_pkg::S_STORE: begin
            if (!sel_ff) begin
               cy_in    = neg_ff ? -x_ff : x_ff;
               sy_in    = neg_ff ? -y_ff : y_ff;
               sel_in   = 1'b1;
               state_in = eco_pkg::S_LOAD;
            end else begin
               cp_in    = neg_ff ? -x_ff : x_ff;
               sp_in    = neg_ff ? -y_ff : y_ff;
               cnt_in   = '0;
               state_in = eco_pkg::S_FRONT;
            end
         end

         eco_pkg::S_FRONT: begin
            fr_t   = prod_ff + (64'sd1 <<< 43);
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               5'd0: begin
                  mul_a = cy_ff;
                  mul_b = cp_ff;
               end
               5'd1: begin
                  f_in[0] = eco_pkg::clamp_q14(21'($signed(fr_t[63:44])));
                  mul_a   = sy_ff;
                  mul_b   = cp_ff;
               end
               default: begin
                  f_in[2]  = eco_pkg::clamp_q14(21'($signed(fr_t[63:44])));
                  fy_t     = 33'(sp_ff) + 33'sd16384;
                  f_in[1]  = eco_pkg::clamp_q14(21'($signed(fy_t[32:15])));
                  cnt_in   = '0;
                  pass_in  = 1'b0;
                  state_in = eco_pkg::S_CROSS;
               end
            endcase
         end

         eco_pkg::S_CROSS: begin
            // Six products; each difference is formed as the second product lands.
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               5'd0: begin
                  mul_a = 32'(av[1]); mul_b = 32'(bv[2]);
               end
               5'd1: begin
                  acc_in = $signed(prod_ff[31:0]);
                  mul_a = 32'(av[2]); mul_b = 32'(bv[1]);
               end
               5'd2: begin
                  c_in[0] = acc_ff - $signed(prod_ff[31:0]);
                  mul_a = 32'(av[2]); mul_b = 32'(bv[0]);
               end
               5'd3: begin
                  acc_in = $signed(prod_ff[31:0]);
                  mul_a = 32'(av[0]); mul_b = 32'(bv[2]);
               end
               5'd4: begin
                  c_in[1] = acc_ff - $signed(prod_ff[31:0]);
                  mul_a = 32'(av[0]); mul_b = 32'(bv[1]);
               end
               5'd5: begin
                  acc_in = $signed(prod_ff[31:0]);
                  mul_a = 32'(av[1]); mul_b = 32'(bv[0]);
               end
               default: begin
                  c_in[2]  = acc_ff - $signed(prod_ff[31:0]);
                  cnt_in   = '0;
                  state_in = eco_pkg::S_SQR;
               end
            endcase
         end

         eco_pkg::S_SQR: begin
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               5'd0: begin
                  rem_in = '0;
                  mul_a = c_ff[0]; mul_b = c_ff[0];
               end
               5'd1: begin
                  rem_in = rem_ff + $unsigned(prod_ff);
                  mul_a = c_ff[1]; mul_b = c_ff[1];
               end
               5'd2: begin
                  rem_in = rem_ff + $unsigned(prod_ff);
                  mul_a = c_ff[2]; mul_b = c_ff[2];
               end
               default: begin
                  rem_in   = rem_ff + $unsigned(prod_ff);
                  root_in  = '0;
                  bit_in   = 64'd1 << 62;
                  iter_in  = '0;
                  state_in = eco_pkg::S_SQRT;
               end
            endcase
         end

         eco_pkg::S_SQRT: begin
            // One result bit per cycle, two radicand bits at a time.
            trial = root_ff + bit_ff;
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               comp_in  = '0;
               cnt_in   = '0;
               state_in = eco_pkg::S_DIV;
            end
         end

         eco_pkg::S_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd0) begin
               // Rounded quotient: (|c| * 2^14 + n/2) / n.
               mag    = c_ff[comp_ff][31] ? 32'(-c_ff[comp_ff]) : 32'(c_ff[comp_ff]);
               num_in = {2'b00, mag, 14'b0} + {17'b0, root_ff[31:1]};
               den_in = {1'b0, root_ff[31:0], 15'b0};
               quo_in = '0;
            end else if (cnt_ff <= 5'd16) begin
               if (num_ff >= den_ff) begin
                  num_in = num_ff - den_ff;
                  quo_in = {quo_ff[14:0], 1'b1};
               end else begin
                  quo_in = {quo_ff[14:0], 1'b0};
               end
               den_in = den_ff >> 1;
            end else begin
               qc = (quo_ff > eco_pkg::QUOT_MAX) ? eco_pkg::QUOT_MAX : quo_ff;
               if (root_ff == 64'd0)
                  qs = '0;
               else if (c_ff[comp_ff][31])
                  qs = -$signed(qc);
               else
                  qs = $signed(qc);
               if (pass_ff) u_in[comp_ff] = qs;
               else         r_in[comp_ff] = qs;
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  if (!pass_ff) begin
                     pass_in  = 1'b1;
                     state_in = eco_pkg::S_CROSS;
                  end else begin
                     state_in = eco_pkg::S_FIN;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end

         eco_pkg::S_FIN: begin
            // Hand over once the result register is free or drains this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               of_in = f_ff; or_in = r_ff; ou_in = u_ff;
               oyaw_in = yaw_ff; opitch_in = pitch_ff; ozoom_in = zoom_ff;
               rsp_valid_in = 1'b1;
               state_in     = eco_pkg::S_IDLE;
            end
         end

         default: state_in = eco_pkg::S_IDLE;
      endcase

      if (csr_valid) begin
         case (csr_index)
            eco_pkg::REG_UP_X:       up_in[0] = $signed(csr_data);
            eco_pkg::REG_UP_Y:       up_in[1] = $signed(csr_data);
            eco_pkg::REG_UP_Z:       up_in[2] = $signed(csr_data);
            eco_pkg::REG_INIT_YAW:   yaw_in = eco_pkg::wrap_angle(18'($signed(csr_data[14:0])));
            eco_pkg::REG_INIT_PITCH: pitch_in = 15'($signed(csr_data[13:0]));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eco_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         yaw_ff       <= eco_pkg::YAW_RESET;
         pitch_ff     <= '0;
         zoom_ff      <= ZOOM_INIT;
         up_ff[0]     <= eco_pkg::UP_X_RESET;
         up_ff[1]     <= eco_pkg::UP_Y_RESET;
         up_ff[2]     <= eco_pkg::UP_Z_RESET;
         sel_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         iter_ff      <= '0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         zoom_ff      <= zoom_in;
         up_ff        <= up_in;
         sel_ff       <= sel_in;
         pass_ff      <= pass_in;
         iter_ff      <= iter_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cy_ff   <= cy_in;
      sy_ff   <= sy_in;
      cp_ff   <= cp_in;
      sp_ff   <= sp_in;
      f_ff    <= f_in;
      r_ff    <= r_in;
      u_ff    <= u_in;
      c_ff    <= c_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
      of_ff   <= of_in;
      or_ff   <= or_in;
      ou_ff   <= ou_in;
      oyaw_ff   <= oyaw_in;
      opitch_ff <= opitch_in;
      ozoom_ff  <= ozoom_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_front_x   = of_ff[0];
   assign rsp_front_y   = of_ff[1];
   assign rsp_front_z   = of_ff[2];
   assign rsp_right_x   = or_ff[0];
   assign rsp_right_y   = or_ff[1];
   assign rsp_right_z   = or_ff[2];
   assign rsp_up_x      = ou_ff[0];
   assign rsp_up_y      = ou_ff[1];
   assign rsp_up_z      = ou_ff[2];
   assign rsp_yaw_now   = oyaw_ff;
   assign rsp_pitch_now = opitch_ff;
   assign rsp_zoom_now  = ozoom_ff;

endmodule
